FILE: rtl/triangle_unit_normal_core_macros.svh
// Assertion macros shared by the triangle unit normal RTL.
`ifndef TRIANGLE_UNIT_NORMAL_CORE_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_MACROS_SVH
`ifndef SYNTH
`define TUN_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("triangle unit normal check failed");
`define TUN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("triangle unit normal check failed");
`else
`define TUN_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TUN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/tun_pkg.sv
// Types and constants of the triangle unit normal block.
package tun_pkg;
  localparam int COORD_W = 32;
  localparam int EDGE_W = 33;
  localparam int PROD_W = 66;
  localparam int MAG_W = 65;
  localparam int LEN_W = 7;
  localparam int SQ_W = 64;
  localparam int SUM_W = 66;
  localparam int M_W = 31;
  localparam int MSQ_W = 62;
  localparam int Q_W = 64;
  localparam int ROOT_W = 32;
  localparam int NUM_W = 63;
  localparam int QUO_W = 31;
  localparam int UNIT_SHIFT = 30;
  localparam int THR_W = 63;
  localparam logic [THR_W-1:0] THR_RESET = 63'd18446744;
  localparam logic [QUO_W-1:0] UNIT_ONE = 31'h4000_0000;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_DEGEN = 1'b1;

  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [M_W-1:0] norm_mag_t;

  typedef struct packed {
    logic degen;
    logic [2:0] neg;
    logic [2:0][M_W-1:0] m;
  } isq_side_t;

  typedef struct packed {
    logic degen;
    logic neg;
  } div_side_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] norm_x;
    logic signed [COORD_W-1:0] norm_y;
    logic signed [COORD_W-1:0] norm_z;
    logic status;
  } res_t;
endpackage

FILE: rtl/tun_ifs.sv
// Channel interfaces of the triangle unit normal block.
interface tun_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] v0_x, v0_y, v0_z;
  logic signed [31:0] v1_x, v1_y, v1_z;
  logic signed [31:0] v2_x, v2_y, v2_z;
  modport source(output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                 input ready);
  modport sink(input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
               output ready);
endinterface

interface tun_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] norm_x, norm_y, norm_z;
  logic status;
  modport source(output valid, norm_x, norm_y, norm_z, status, input ready);
  modport sink(input valid, norm_x, norm_y, norm_z, status, output ready);
endinterface

interface tun_cfg_if;
  logic valid;
  logic ready;
  logic [62:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

FILE: rtl/tun_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module tun_isqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [63:0] in_q,
  input  tun_pkg::isq_side_t in_side,
  output logic out_valid,
  output logic [31:0] out_root,
  output tun_pkg::isq_side_t out_side
);
  import tun_pkg::*;

  logic vld [ROOT_W];
  logic [Q_W-1:0] rem [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  isq_side_t side [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int I = ROOT_W - 1 - s;
    logic vin;
    logic [Q_W-1:0] rin;
    logic [ROOT_W-1:0] qin;
    isq_side_t sin;
    logic [Q_W+1:0] remx, trial, diff;
    logic ge;

    if (s == 0) begin : g_first
      assign vin = in_valid;
      assign rin = in_q;
      assign qin = '0;
      assign sin = in_side;
    end else begin : g_next
      assign vin = vld[s-1];
      assign rin = rem[s-1];
      assign qin = root[s-1];
      assign sin = side[s-1];
    end

    assign remx = {2'b00, rin};
    assign trial = ({{(Q_W+2-ROOT_W){1'b0}}, qin} << (I + 1)) + ((Q_W+2)'(1) << (2 * I));
    assign ge = remx >= trial;
    assign diff = remx - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? diff[Q_W-1:0] : rin;
        root[s] <= ge ? (qin | (ROOT_W'(1) << I)) : qin;
        side[s] <= sin;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root = root[ROOT_W-1];
  assign out_side = side[ROOT_W-1];
endmodule

FILE: rtl/tun_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module tun_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [62:0] in_num,
  input  logic [31:0] in_den,
  input  tun_pkg::div_side_t in_side,
  output logic out_valid,
  output logic [30:0] out_quo,
  output tun_pkg::div_side_t out_side
);
  import tun_pkg::*;

  logic vld [QUO_W];
  logic [NUM_W-1:0] rem [QUO_W];
  logic [ROOT_W-1:0] den [QUO_W];
  logic [QUO_W-1:0] quo [QUO_W];
  div_side_t side [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int I = QUO_W - 1 - s;
    logic vin;
    logic [NUM_W-1:0] rin, dsh;
    logic [ROOT_W-1:0] din;
    logic [QUO_W-1:0] qin;
    div_side_t sin;
    logic ge;

    if (s == 0) begin : g_first
      assign vin = in_valid;
      assign rin = in_num;
      assign din = in_den;
      assign qin = '0;
      assign sin = in_side;
    end else begin : g_next
      assign vin = vld[s-1];
      assign rin = rem[s-1];
      assign din = den[s-1];
      assign qin = quo[s-1];
      assign sin = side[s-1];
    end

    assign dsh = {{(NUM_W-ROOT_W){1'b0}}, din} << I;
    assign ge = rin >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? rin - dsh : rin;
        quo[s] <= ge ? (qin | (QUO_W'(1) << I)) : qin;
        den[s] <= din;
        side[s] <= sin;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_quo = quo[QUO_W-1];
  assign out_side = side[QUO_W-1];
endmodule

FILE: rtl/triangle_unit_normal_core.sv
// Triangle unit normal: takes one triangle per clock while the skid register is empty and
// returns its unit face normal in Q2.30 or a degenerate status. The pipeline has 72
// register stages: seven stages of edge, cross-product and normalization arithmetic, a
// 32-stage square root, a prepare stage, three parallel 31-stage dividers and the output
// register, each root or divider stage resolving one bit. A new triangle is accepted every
// cycle while the skid register is empty; an output register and a one-entry skid register
// keep input ready while a result waits, and the pipeline holds when the skid register is
// full.
module triangle_unit_normal_core (
  input  logic clk,
  input  logic rst,
  tun_in_if.sink tri_in,
  tun_out_if.source norm_out,
  tun_cfg_if.sink cfg
);
  import tun_pkg::*;
  `include "triangle_unit_normal_core_macros.svh"

  logic [THR_W-1:0] thr;
  logic en;
  logic skid_valid, out_valid;
  res_t skid_res, out_res, fin_res;
  logic fin_valid;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg.valid) begin
      thr <= cfg.data;
    end
  end

  assign en = !skid_valid;
  assign tri_in.ready = en;

  // Edge vectors.
  logic v1;
  edge_t a [3], b [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= tri_in.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a[0] <= EDGE_W'(tri_in.v1_x) - EDGE_W'(tri_in.v0_x);
      a[1] <= EDGE_W'(tri_in.v1_y) - EDGE_W'(tri_in.v0_y);
      a[2] <= EDGE_W'(tri_in.v1_z) - EDGE_W'(tri_in.v0_z);
      b[0] <= EDGE_W'(tri_in.v2_x) - EDGE_W'(tri_in.v0_x);
      b[1] <= EDGE_W'(tri_in.v2_y) - EDGE_W'(tri_in.v0_y);
      b[2] <= EDGE_W'(tri_in.v2_z) - EDGE_W'(tri_in.v0_z);
    end
  end

  // Cross-product partial products.
  logic v2;
  prod_t pl [3], pr [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pl[0] <= a[1] * b[2];
      pr[0] <= a[2] * b[1];
      pl[1] <= a[2] * b[0];
      pr[1] <= a[0] * b[2];
      pl[2] <= a[0] * b[1];
      pr[2] <= a[1] * b[0];
    end
  end

  // Cross product as sign and magnitude.
  logic v3;
  mag_t mag3 [3];
  logic [2:0] neg3;
  logic signed [PROD_W:0] dif [3];
  logic [PROD_W:0] absd [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k] = {pl[k][PROD_W-1], pl[k]} - {pr[k][PROD_W-1], pr[k]};
      absd[k] = dif[k][PROD_W] ? (~dif[k] + 1'b1) : dif[k];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag3[k] <= absd[k][MAG_W-1:0];
        neg3[k] <= dif[k][PROD_W];
      end
    end
  end

  // Squares of small components and the leading bit position.
  logic v4;
  logic [SQ_W-1:0] sq4 [3];
  mag_t mag4 [3];
  logic [2:0] neg4;
  logic big4;
  logic [LEN_W-1:0] len4, len_c;
  mag_t orv;
  always_comb begin
    orv = mag3[0] | mag3[1] | mag3[2];
    len_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) begin
        len_c = LEN_W'(i + 1);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq4[k] <= mag3[k][31:0] * mag3[k][31:0];
        mag4[k] <= mag3[k];
      end
      neg4 <= neg3;
      big4 <= |orv[MAG_W-1:32];
      len4 <= len_c;
    end
  end

  // Degeneracy test and normalizing shift.
  logic v5;
  norm_mag_t m5 [3];
  logic [2:0] neg5;
  logic degen5;
  logic [SUM_W-1:0] ssum;
  logic [MAG_W+M_W-1:0] shv [3];
  always_comb begin
    ssum = SUM_W'(sq4[0]) + SUM_W'(sq4[1]) + SUM_W'(sq4[2]);
    for (int k = 0; k < 3; k++) begin
      shv[k] = {mag4[k], {M_W{1'b0}}} >> len4;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m5[k] <= shv[k][M_W-1:0];
      end
      neg5 <= neg4;
      degen5 <= !big4 && (ssum <= SUM_W'(thr));
    end
  end

  // Squares of normalized components.
  logic v6;
  logic [MSQ_W-1:0] msq6 [3];
  isq_side_t side6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        msq6[k] <= m5[k] * m5[k];
        side6.m[k] <= m5[k];
      end
      side6.neg <= neg5;
      side6.degen <= degen5;
    end
  end

  logic v7;
  logic [Q_W-1:0] q7;
  isq_side_t side7;
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q7 <= Q_W'(msq6[0]) + Q_W'(msq6[1]) + Q_W'(msq6[2]);
      side7 <= side6;
    end
  end

  logic vr;
  logic [ROOT_W-1:0] root;
  isq_side_t sider;
  tun_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v7), .in_q(q7), .in_side(side7),
    .out_valid(vr), .out_root(root), .out_side(sider)
  );

  // Dividend and divisor for each component.
  logic vp;
  logic [NUM_W-1:0] num [3];
  logic [ROOT_W-1:0] den;
  div_side_t dside [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= vr;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num[k] <= NUM_W'({sider.m[k], {UNIT_SHIFT{1'b0}}}) + NUM_W'(root >> 1);
        dside[k].neg <= sider.neg[k];
        dside[k].degen <= sider.degen;
      end
      den <= (root == '0) ? ROOT_W'(1) : root;
    end
  end

  logic dv [3];
  logic [QUO_W-1:0] quo [3];
  div_side_t qside [3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    tun_div u_div (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(vp), .in_num(num[k]), .in_den(den), .in_side(dside[k]),
      .out_valid(dv[k]), .out_quo(quo[k]), .out_side(qside[k])
    );
  end

  logic [COORD_W-1:0] comp [3];
  logic [QUO_W-1:0] qc [3];
  logic fin_degen;
  always_comb begin
    fin_degen = qside[0].degen | qside[1].degen | qside[2].degen;
    for (int k = 0; k < 3; k++) begin
      qc[k] = (quo[k] > UNIT_ONE) ? UNIT_ONE : quo[k];
      comp[k] = qside[k].neg ? (~COORD_W'(qc[k]) + 1'b1) : COORD_W'(qc[k]);
      if (fin_degen) begin
        comp[k] = '0;
      end
    end
    fin_valid = dv[0];
    fin_res.norm_x = comp[0];
    fin_res.norm_y = comp[1];
    fin_res.norm_z = comp[2];
    fin_res.status = fin_degen ? STATUS_DEGEN : STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (norm_out.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (fin_valid) begin
      if (!out_valid || norm_out.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (norm_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (norm_out.ready) begin
        out_res <= skid_res;
      end
    end else if (fin_valid) begin
      if (!out_valid || norm_out.ready) begin
        out_res <= fin_res;
      end else begin
        skid_res <= fin_res;
      end
    end
  end

  assign norm_out.valid = out_valid;
  assign norm_out.norm_x = out_res.norm_x;
  assign norm_out.norm_y = out_res.norm_y;
  assign norm_out.norm_z = out_res.norm_z;
  assign norm_out.status = out_res.status;

  `TUN_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `TUN_ASSERT_IMPL(a_degen_zero, clk, rst, norm_out.valid && norm_out.status == STATUS_DEGEN, norm_out.norm_x == '0 && norm_out.norm_y == '0 && norm_out.norm_z == '0)
  `TUN_ASSERT_NEXT(a_stall_holds, clk, rst, skid_valid && !norm_out.ready, skid_valid && $stable(skid_res))
endmodule
